[src/lfu_pkg.sv]
package lfu_pkg;

  // table geometry
  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // request opcodes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lfu_rsp_t;

endpackage

[src/lfu_cache_lru_tiebreak.sv]
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------------
// request  | start, busy, in_req            | item taken when start && !busy
// result   | out_valid, out_rsp             | one-cycle strobe, cannot be held off
// config   | cfg_we, cfg_wdata              | capacity written when cfg_we is high
//
// an item is scanned one entry per cycle through the shared key / use count / rank
// compare unit, then goes through the update state
// with zero capacity the result appears the cycle after the item is taken
// synchronous active-low reset clears all valid bits and occupancy and sets capacity to 16
// busy is high while an item is being worked on; results are never stalled
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lfu_req_t         in_req,
  output logic             out_valid,
  output lfu_rsp_t         out_rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPDT = 2'd2;
  localparam int         CMP_W   = OCC_W + CAP_W;

  // entry storage
  logic               valid_r [ENTRIES];
  logic [DATA_W-1:0]  key_r   [ENTRIES];
  logic [DATA_W-1:0]  val_r   [ENTRIES];
  logic [CNT_W-1:0]   cnt_r   [ENTRIES];
  logic [IDX_W-1:0]   rank_r  [ENTRIES];

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [OCC_W-1:0]   occ_r;
  logic [CAP_W-1:0]   cap_r;
  lfu_req_t           req_r;

  // scan results
  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic [DATA_W-1:0]  match_val_r;
  logic [CNT_W-1:0]   match_cnt_r;
  logic [IDX_W-1:0]   match_rank_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               vic_found_r;
  logic [IDX_W-1:0]   vic_idx_r;
  logic [CNT_W-1:0]   vic_cnt_r;
  logic [IDX_W-1:0]   vic_rank_r;
  logic [DATA_W-1:0]  vic_key_r;

  logic               out_valid_r;
  lfu_rsp_t           out_rsp_r;

  logic               accept;
  logic [OCC_W-1:0]   cap_eff;
  logic               last_idx;
  logic               cur_valid;
  logic [DATA_W-1:0]  cur_key;
  logic [CNT_W-1:0]   cur_cnt;
  logic [IDX_W-1:0]   cur_rank;
  logic               hit_now;
  logic               free_now;
  logic               vic_now;
  logic               use_free;
  logic [IDX_W-1:0]   fill_idx;
  logic               touch;
  logic [IDX_W-1:0]   touch_idx;
  logic [OCC_W:0]     touch_old;
  logic [CNT_W-1:0]   cnt_inc;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign last_idx = (idx_r == IDX_W'(ENTRIES - 1));

  // effective capacity, clamped to the table size
  assign cap_eff = (CMP_W'(cap_r) > CMP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(cap_r);

  // shared compare unit over the entry under the scan pointer
  assign cur_valid = valid_r[idx_r];
  assign cur_key   = key_r[idx_r];
  assign cur_cnt   = cnt_r[idx_r];
  assign cur_rank  = rank_r[idx_r];
  assign hit_now   = cur_valid && !match_found_r && (cur_key == DATA_W'(req_r.key));
  assign free_now  = !cur_valid && !free_found_r;
  assign vic_now   = cur_valid && (!vic_found_r || (cur_cnt < vic_cnt_r) ||
                     ((cur_cnt == vic_cnt_r) && (cur_rank > vic_rank_r)));

  // update decisions
  assign use_free  = free_found_r && (occ_r < cap_eff);
  assign fill_idx  = use_free ? free_idx_r : vic_idx_r;
  assign cnt_inc   = (match_cnt_r == COUNT_MAX) ? match_cnt_r : match_cnt_r + 1'b1;
  assign touch     = (state_r == ST_UPDT) &&
                     (match_found_r || (req_r.command == CMD_PUT));
  assign touch_idx = match_found_r ? match_idx_r : fill_idx;
  always_comb begin
    if (match_found_r) begin
      touch_old = (OCC_W + 1)'(match_rank_r);
    end else if (use_free) begin
      touch_old = (OCC_W + 1)'(ENTRIES);
    end else begin
      touch_old = (OCC_W + 1)'(vic_rank_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (cap_eff != '0)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_idx) state_nxt = ST_UPDT;
      end
      ST_UPDT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && (cap_eff == '0)) || (state_r == ST_UPDT);
      if (cfg_we) cap_r <= cfg_wdata;
      if ((state_r == ST_UPDT) && !match_found_r && (req_r.command == CMD_PUT) && use_free)
        occ_r <= occ_r + 1'b1;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
    end else if ((state_r == ST_UPDT) && !match_found_r && (req_r.command == CMD_PUT)) begin
      valid_r[fill_idx] <= 1'b1;
    end
  end

  // scan pointer and scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r         <= in_req;
      idx_r         <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      idx_r <= idx_r + 1'b1;
      if (hit_now) begin
        match_found_r <= 1'b1;
        match_idx_r   <= idx_r;
        match_val_r   <= val_r[idx_r];
        match_cnt_r   <= cur_cnt;
        match_rank_r  <= cur_rank;
      end
      if (free_now) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (vic_now) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= idx_r;
        vic_cnt_r   <= cur_cnt;
        vic_rank_r  <= cur_rank;
        vic_key_r   <= cur_key;
      end
    end
  end

  // entry payload writes
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDT) begin
      if (match_found_r) begin
        cnt_r[match_idx_r] <= cnt_inc;
        if (req_r.command == CMD_PUT) val_r[match_idx_r] <= DATA_W'(req_r.value);
      end else if (req_r.command == CMD_PUT) begin
        key_r[fill_idx] <= DATA_W'(req_r.key);
        val_r[fill_idx] <= DATA_W'(req_r.value);
        cnt_r[fill_idx] <= CNT_W'(1);
      end
    end
  end

  // recency ranks: touched entry becomes newest, younger valid entries age
  always_ff @(posedge clk) begin
    if (touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == touch_idx) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && ((OCC_W + 1)'(rank_r[i]) < touch_old)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept && (cap_eff == '0)) begin
      out_rsp_r <= '0;
    end else if (state_r == ST_UPDT) begin
      out_rsp_r.hit         <= match_found_r;
      out_rsp_r.read_value  <= (match_found_r && (req_r.command == CMD_GET)) ?
                               match_val_r : '0;
      out_rsp_r.evicted     <= !match_found_r && (req_r.command == CMD_PUT) && !use_free;
      out_rsp_r.evicted_key <= (!match_found_r && (req_r.command == CMD_PUT) && !use_free) ?
                               vic_key_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

[src/lfu_checker.sv]
module lfu_checker
  import lfu_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input lfu_rsp_t out_rsp
);

  // a taken item either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("item taken but neither busy nor answered");

  // finishing an item always produces its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // an eviction is a put miss, so no hit and no read value
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.evicted) |-> (!out_rsp.hit && (out_rsp.read_value == 0)))
    else $error("eviction reported with hit or read value");

  // evicted key is zero unless something was evicted
  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.evicted) |-> (out_rsp.evicted_key == 0))
    else $error("evicted key without eviction");

  // a miss returns no value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.hit) |-> (out_rsp.read_value == 0))
    else $error("read value on a miss");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (.*);

[verif/tb_lfu_cache_lru_tiebreak.sv]
`timescale 1ns / 1ps

module tb_lfu_cache_lru_tiebreak;
  import lfu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = ENTRIES + 6;
  localparam int POOL_MAX       = 24;

  // dut connections
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  lfu_req_t         in_req = '0;
  logic             out_valid;
  lfu_rsp_t         out_rsp;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  lfu_cache_lru_tiebreak dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the cache contents
  bit          shadow_valid [ENTRIES];
  bit [31:0]   shadow_key   [ENTRIES];
  bit [31:0]   shadow_value [ENTRIES];
  bit [31:0]   shadow_uses  [ENTRIES];
  int          shadow_rank  [ENTRIES];
  int          shadow_occupied;
  int unsigned shadow_capacity;

  // stimulus and scoreboard state
  lfu_req_t    request_q[$];
  lfu_rsp_t    response_q[$];
  lfu_req_t    held_req;
  bit          req_held;
  int          send_idle_pct;
  int          mismatches;
  int          quiet_cycles;
  bit [31:0]   key_pool [POOL_MAX];
  int          pool_size;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // move slot s to the front of the recency order
  function automatic void promote(int s, int old_rank);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank) begin
        shadow_rank[i]++;
      end
    end
    shadow_rank[s] = 0;
  endfunction

  // apply one request to the shadow cache and return the response it gives
  function automatic lfu_rsp_t cache_access(lfu_req_t r);
    lfu_rsp_t rsp;
    int       cap_eff;
    int       found;
    int       slot;
    int       i;
    rsp     = '0;
    cap_eff = (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
    found   = -1;
    slot    = -1;
    if (cap_eff == 0) begin
      return rsp;
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_key[i] == r.key) begin
        found = i;
        break;
      end
    end
    // hit: bump use count (saturating) and recency
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (shadow_uses[found] != COUNT_MAX) begin
        shadow_uses[found]++;
      end
      promote(found, shadow_rank[found]);
      if (r.command == CMD_PUT) begin
        shadow_value[found] = r.value;
      end else begin
        rsp.read_value = shadow_value[found];
      end
      return rsp;
    end
    if (r.command == CMD_GET) begin
      return rsp;
    end
    // put miss: free slot if under capacity, else lowest count, oldest among ties
    if (shadow_occupied < cap_eff) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (!shadow_valid[i]) begin
          slot = i;
          break;
        end
      end
    end
    if (slot >= 0) begin
      shadow_valid[slot] = 1'b1;
      promote(slot, ENTRIES);
      shadow_occupied++;
    end else begin
      for (i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && (slot < 0 || shadow_uses[i] < shadow_uses[slot] ||
            (shadow_uses[i] == shadow_uses[slot] && shadow_rank[i] > shadow_rank[slot]))) begin
          slot = i;
        end
      end
      rsp.evicted     = 1'b1;
      rsp.evicted_key = shadow_key[slot];
      promote(slot, shadow_rank[slot]);
    end
    shadow_key[slot]   = r.key;
    shadow_value[slot] = r.value;
    shadow_uses[slot]  = 1;
    return rsp;
  endfunction

  // driver: hold one item until taken, raise start unless idling
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      req_held = 1'b0;
    end else begin
      if (start && !busy) begin
        response_q.push_back(cache_access(held_req));
        req_held = 1'b0;
      end
      if (!req_held && request_q.size() > 0) begin
        held_req = request_q.pop_front();
        in_req  <= held_req;
        req_held = 1'b1;
      end
      start <= req_held && ($urandom_range(99) >= send_idle_pct);
    end
  end

  // monitor: compare each result with the oldest expected one
  always @(posedge clk) begin
    lfu_rsp_t want;
    if (rst_n && out_valid) begin
      if (response_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: hit=%b read=%h evicted=%b evicted_key=%h",
                   out_rsp.hit, out_rsp.read_value, out_rsp.evicted, out_rsp.evicted_key);
        end
      end else begin
        want = response_q.pop_front();
        if (out_rsp.hit !== want.hit || out_rsp.read_value !== want.read_value ||
            out_rsp.evicted !== want.evicted || out_rsp.evicted_key !== want.evicted_key) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected hit=%b read=%h evicted=%b evicted_key=%h",
                     want.hit, want.read_value, want.evicted, want.evicted_key);
            $display("          actual   hit=%b read=%h evicted=%b evicted_key=%h",
                     out_rsp.hit, out_rsp.read_value, out_rsp.evicted, out_rsp.evicted_key);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lfu_cache_lru_tiebreak verification failed");
      $finish;
    end
  end

  task automatic queue_item(logic cmd, bit [31:0] k, bit [31:0] v);
    lfu_req_t r;
    r.command = cmd;
    r.key     = k;
    r.value   = v;
    request_q.push_back(r);
  endtask

  // wait for every item to drain, then write the capacity
  task automatic set_capacity(int unsigned cap);
    wait (request_q.size() == 0 && !req_held && response_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(cap);
    shadow_capacity = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random traffic mostly over a small key pool so hits and evictions are common
  task automatic random_phase(int unsigned cap, int idle_pct, int n);
    int        cap_eff;
    int        i;
    bit [31:0] k;
    set_capacity(cap);
    send_idle_pct = idle_pct;
    cap_eff   = (cap > ENTRIES) ? ENTRIES : int'(cap);
    pool_size = (cap_eff + 4 > POOL_MAX) ? POOL_MAX : cap_eff + 4;
    for (i = 0; i < pool_size; i++) begin
      case ($urandom_range(9))
        0:       key_pool[i] = 32'h8000_0000;
        1:       key_pool[i] = 32'h7fff_ffff;
        2:       key_pool[i] = 32'hffff_ffff;
        3:       key_pool[i] = 32'h0000_0000;
        default: key_pool[i] = $urandom;
      endcase
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 88) begin
        k = key_pool[$urandom_range(pool_size - 1)];
      end else begin
        k = $urandom;
      end
      queue_item(($urandom_range(1) == 1) ? CMD_PUT : CMD_GET, k, $urandom);
    end
  endtask

  // main sequence
  initial begin
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
    end
    shadow_occupied = 0;
    shadow_capacity = CAP_RESET;
    send_idle_pct   = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, hit and miss of each command, then a fill and evictions
    queue_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_item(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_item(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_item(CMD_GET, 32'h8000_0000, 32'h5555_5555);
    queue_item(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
    queue_item(CMD_PUT, 32'hffff_ffff, 32'haaaa_aaaa);
    queue_item(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
    queue_item(CMD_GET, 32'h1234_5678, 32'h0000_0000);
    for (i = 0; i < 12; i++) begin
      queue_item(CMD_PUT, 32'h100 + i, $urandom);
    end
    queue_item(CMD_PUT, 32'h200, 32'hdead_beef);
    queue_item(CMD_PUT, 32'h201, 32'hcafe_f00d);
    queue_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);

    // capacity below occupancy, zero, above the table size, and the extremes
    random_phase(16, 0, 110);
    random_phase(2, 21, 60);
    random_phase(0, 67, 40);
    random_phase(31, 0, 90);
    random_phase(1, 67, 70);
    random_phase(17, 21, 90);
    random_phase(5, 0, 90);
    random_phase(0, 21, 20);
    random_phase(16, 67, 100);

    wait (request_q.size() == 0 && !req_held && response_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && response_q.size() == 0) begin
      $display("lfu_cache_lru_tiebreak verification clean");
    end else begin
      $display("lfu_cache_lru_tiebreak verification failed");
    end
    $finish;
  end

endmodule
